[hw/rtl/rpa_pkg.sv]
package rpa_pkg;

  localparam int VAL_W     = 32;
  localparam int FRAC_W    = 16;
  localparam int CNT_W     = 32;
  localparam int TGT_W     = 8;
  localparam int SUM_W     = 48;
  localparam int IDX_W     = 2;
  localparam int TU_W      = CNT_W + 1;
  // kd products at or above 2^KD_X_W give a quotient past the 32-bit range
  localparam int KD_X_W    = 38;
  localparam int MCAND_W   = KD_X_W;
  localparam int MPLR_W    = 39;
  localparam int PROD_W    = MCAND_W + MPLR_W;
  localparam int DIV_W     = 64;
  localparam int DEN_SHIFT = 30 - FRAC_W;
  localparam int MCNT_W    = $clog2(MPLR_W + 1);
  localparam int DCNT_W    = $clog2(DIV_W + 1);

  // 4/pi in Q30
  localparam logic [MPLR_W-1:0] FOUR_OVER_PI = MPLR_W'(1367130551);

  // reciprocals: x/5 = (x * RECIP_5) >> KP_SHIFT for x below 2^32,
  // x/100 = (x * RECIP_100) >> KD_SHIFT for x below 2^KD_X_W
  localparam logic [MPLR_W-1:0] RECIP_5   = MPLR_W'(64'd3435973837);
  localparam int                KP_SHIFT  = 34;
  localparam logic [MPLR_W-1:0] RECIP_100 = MPLR_W'(64'd351843720889);
  localparam int                KD_SHIFT  = 45;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic [IDX_W-1:0] REG_SET_POINT    = 2'd0;
  localparam logic [IDX_W-1:0] REG_OUT_MIN      = 2'd1;
  localparam logic [IDX_W-1:0] REG_OUT_MAX      = 2'd2;
  localparam logic [IDX_W-1:0] REG_CYCLE_TARGET = 2'd3;

  localparam logic [1:0] LANE_P = 2'd0;
  localparam logic [1:0] LANE_I = 2'd1;
  localparam logic [1:0] LANE_D = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_KU_MUL,
    S_KU_MUL_WAIT,
    S_KU_DIV,
    S_KU_DIV_WAIT,
    S_KP_MUL,
    S_KP_MUL_WAIT,
    S_KI_DIV,
    S_KI_WAIT,
    S_KD_MUL,
    S_KD_MUL_WAIT,
    S_KD_SCALE,
    S_KD_SCALE_WAIT,
    S_ACCUM,
    S_FIN_CHECK,
    S_AVG_DIV,
    S_AVG_WAIT,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    SEL_KU,
    SEL_KP,
    SEL_KI,
    SEL_KD,
    SEL_KD_SCALE,
    SEL_AVG
  } sel_t;

  typedef struct packed {
    logic       load;
    logic       mul_go;
    logic       div_go;
    logic       wr;
    sel_t       sel;
    logic [1:0] lane;
    logic       apply_up;
    logic       finish;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic start_item;
    logic running;
    logic up_switch;
    logic mul_busy;
    logic div_busy;
    logic fin_due;
    logic n_zero;
    logic out_free;
  } status_t;

  // truncated quotient with sign applied, clamped to the signed value range
  function automatic logic signed [VAL_W-1:0] sat_val(input logic neg,
                                                      input logic [DIV_W-1:0] q);
    logic signed [VAL_W-1:0] r;
    if (neg) begin
      if (q > DIV_W'(VAL_MAX) + DIV_W'(1)) r = VAL_MIN;
      else r = VAL_W'(0) - q[VAL_W-1:0];
    end else begin
      if (q > DIV_W'(VAL_MAX)) r = VAL_MAX;
      else r = q[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/rpa_if.sv]
interface rpa_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [rpa_pkg::VAL_W-1:0]    sample_value;
  modport source(output valid, action, sample_value, input ready);
  modport sink(input valid, action, sample_value, output ready);
endinterface

interface rpa_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rpa_pkg::VAL_W-1:0]    drive_value;
  logic                                relay_high;
  logic                                finished;
  logic signed [rpa_pkg::VAL_W-1:0]    gain_p;
  logic signed [rpa_pkg::VAL_W-1:0]    gain_i;
  logic signed [rpa_pkg::VAL_W-1:0]    gain_d;
  modport source(output valid, drive_value, relay_high, finished, gain_p, gain_i, gain_d,
                 input ready);
  modport sink(input valid, drive_value, relay_high, finished, gain_p, gain_i, gain_d,
               output ready);
endinterface

[hw/rtl/rpa_ctrl.sv]
module rpa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rpa_pkg::status_t status,
  output rpa_pkg::cmd_t    cmd
);

  rpa_pkg::state_t state, state_next;
  logic [1:0]      lane, lane_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpa_pkg::S_IDLE;
      lane  <= rpa_pkg::LANE_P;
    end else begin
      state <= state_next;
      lane  <= lane_next;
    end
  end

  always_comb begin
    state_next = state;
    lane_next  = lane;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.sel    = rpa_pkg::SEL_KU;
    cmd.lane   = lane;
    case (state)
      rpa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.start_item || !status.running) state_next = rpa_pkg::S_OUT;
          else if (status.up_switch) state_next = rpa_pkg::S_KU_MUL;
          else state_next = rpa_pkg::S_FIN_CHECK;
        end
      end
      rpa_pkg::S_KU_MUL: begin
        cmd.mul_go = 1'b1;
        state_next = rpa_pkg::S_KU_MUL_WAIT;
      end
      rpa_pkg::S_KU_MUL_WAIT: begin
        if (!status.mul_busy) state_next = rpa_pkg::S_KU_DIV;
      end
      rpa_pkg::S_KU_DIV: begin
        cmd.div_go = 1'b1;
        state_next = rpa_pkg::S_KU_DIV_WAIT;
      end
      rpa_pkg::S_KU_DIV_WAIT: begin
        if (!status.div_busy) begin
          cmd.wr     = 1'b1;
          state_next = rpa_pkg::S_KP_MUL;
        end
      end
      rpa_pkg::S_KP_MUL: begin
        cmd.sel    = rpa_pkg::SEL_KP;
        cmd.mul_go = 1'b1;
        state_next = rpa_pkg::S_KP_MUL_WAIT;
      end
      rpa_pkg::S_KP_MUL_WAIT: begin
        cmd.sel = rpa_pkg::SEL_KP;
        if (!status.mul_busy) begin
          cmd.wr     = 1'b1;
          state_next = rpa_pkg::S_KI_DIV;
        end
      end
      rpa_pkg::S_KI_DIV: begin
        cmd.sel    = rpa_pkg::SEL_KI;
        cmd.div_go = 1'b1;
        state_next = rpa_pkg::S_KI_WAIT;
      end
      rpa_pkg::S_KI_WAIT: begin
        cmd.sel = rpa_pkg::SEL_KI;
        if (!status.div_busy) begin
          cmd.wr     = 1'b1;
          state_next = rpa_pkg::S_KD_MUL;
        end
      end
      rpa_pkg::S_KD_MUL: begin
        cmd.sel    = rpa_pkg::SEL_KD;
        cmd.mul_go = 1'b1;
        state_next = rpa_pkg::S_KD_MUL_WAIT;
      end
      rpa_pkg::S_KD_MUL_WAIT: begin
        cmd.sel = rpa_pkg::SEL_KD;
        if (!status.mul_busy) state_next = rpa_pkg::S_KD_SCALE;
      end
      rpa_pkg::S_KD_SCALE: begin
        cmd.sel    = rpa_pkg::SEL_KD_SCALE;
        cmd.mul_go = 1'b1;
        state_next = rpa_pkg::S_KD_SCALE_WAIT;
      end
      rpa_pkg::S_KD_SCALE_WAIT: begin
        cmd.sel = rpa_pkg::SEL_KD_SCALE;
        if (!status.mul_busy) begin
          cmd.wr     = 1'b1;
          state_next = rpa_pkg::S_ACCUM;
        end
      end
      rpa_pkg::S_ACCUM: begin
        cmd.apply_up = 1'b1;
        state_next   = rpa_pkg::S_FIN_CHECK;
      end
      rpa_pkg::S_FIN_CHECK: begin
        lane_next = rpa_pkg::LANE_P;
        if (status.fin_due) begin
          cmd.finish = 1'b1;
          state_next = status.n_zero ? rpa_pkg::S_OUT : rpa_pkg::S_AVG_DIV;
        end else begin
          state_next = rpa_pkg::S_OUT;
        end
      end
      rpa_pkg::S_AVG_DIV: begin
        cmd.sel    = rpa_pkg::SEL_AVG;
        cmd.div_go = 1'b1;
        state_next = rpa_pkg::S_AVG_WAIT;
      end
      rpa_pkg::S_AVG_WAIT: begin
        cmd.sel = rpa_pkg::SEL_AVG;
        if (!status.div_busy) begin
          cmd.wr = 1'b1;
          if (lane == rpa_pkg::LANE_D) begin
            state_next = rpa_pkg::S_OUT;
          end else begin
            lane_next  = lane + 2'd1;
            state_next = rpa_pkg::S_AVG_DIV;
          end
        end
      end
      rpa_pkg::S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = rpa_pkg::S_IDLE;
        end
      end
      default: state_next = rpa_pkg::S_IDLE;
    endcase
  end

endmodule

[hw/rtl/rpa_datapath.sv]
module rpa_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rpa_pkg::IDX_W-1:0]          cfg_index,
  input  logic [rpa_pkg::VAL_W-1:0]          cfg_data,
  input  logic                               in_action,
  input  logic signed [rpa_pkg::VAL_W-1:0]   in_sample,
  input  rpa_pkg::cmd_t                      cmd,
  output rpa_pkg::status_t                   status,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [rpa_pkg::VAL_W-1:0]   out_drive,
  output logic                               out_relay,
  output logic                               out_finished,
  output logic signed [rpa_pkg::VAL_W-1:0]   out_gain_p,
  output logic signed [rpa_pkg::VAL_W-1:0]   out_gain_i,
  output logic signed [rpa_pkg::VAL_W-1:0]   out_gain_d
);

  localparam int VW = rpa_pkg::VAL_W;
  localparam int SW = rpa_pkg::SUM_W;
  localparam int DW = rpa_pkg::DIV_W;
  localparam int PW = rpa_pkg::PROD_W;
  localparam int CW = rpa_pkg::CNT_W;
  localparam int TW = rpa_pkg::TGT_W;

  // configuration
  logic signed [VW-1:0] set_point, out_min, out_max;
  logic [TW-1:0]        cycle_target;

  // tuning state
  logic                 relay_state, running;
  logic [TW-1:0]        cycle_count;
  logic signed [VW-1:0] peak_high, peak_low;
  logic [CW-1:0]        half_count, high_dur, low_dur;
  logic signed [SW-1:0] sum_acc [3];
  logic signed [VW-1:0] gain_p, gain_i, gain_d, ku;

  // shift-add multiplier
  logic [PW-1:0]                    m_acc, m_cand;
  logic [rpa_pkg::MPLR_W-1:0]       m_plr;
  logic [rpa_pkg::MCNT_W-1:0]       m_cnt;
  logic                             m_busy;

  // restoring divider
  logic [DW-1:0]                    d_rem, d_quo, d_den;
  logic [rpa_pkg::DCNT_W-1:0]       d_cnt;
  logic                             d_busy;
  logic [DW:0]                      d_trial;
  logic                             d_ge;

  logic signed [VW:0]          diff, amp;
  logic [VW:0]                 diff_mag, amp_mag;
  logic [rpa_pkg::TU_W-1:0]    tu;
  logic [VW-1:0]               kp_mag, ku_mag;
  logic [rpa_pkg::MCAND_W-1:0] kp33;
  logic [TW-1:0]               avg_n;
  logic signed [SW-1:0]        lane_sum;
  logic [SW-1:0]               lane_mag;

  logic [DW-1:0]                    div_num, div_den;
  logic                             div_neg;
  logic [rpa_pkg::MCAND_W-1:0]      mul_cand;
  logic [rpa_pkg::MPLR_W-1:0]       mul_plr;
  logic signed [VW-1:0]             q_sat;
  logic [DW-1:0]                    rec_quo;
  logic                             kd_big;

  logic [CW-1:0]        half_inc;
  logic signed [VW-1:0] peak_high_new, peak_low_new;
  logic                 sw_down, sw_up;

  assign diff     = {out_max[VW-1], out_max} - {out_min[VW-1], out_min};
  assign amp      = {peak_high[VW-1], peak_high} - {peak_low[VW-1], peak_low};
  assign diff_mag = diff[VW] ? (VW+1)'(0) - diff : diff;
  assign amp_mag  = amp[VW] ? (VW+1)'(0) - amp : amp;
  assign tu       = {1'b0, high_dur} + {1'b0, low_dur};
  assign kp_mag   = gain_p[VW-1] ? VW'(0) - gain_p : gain_p;
  assign ku_mag   = ku[VW-1] ? VW'(0) - ku : ku;
  assign kp33     = rpa_pkg::MCAND_W'({kp_mag, 5'b0}) + rpa_pkg::MCAND_W'(kp_mag);
  assign avg_n    = (cycle_count >= TW'(2)) ? cycle_count - TW'(2) : TW'(0);

  always_comb begin
    case (cmd.lane)
      rpa_pkg::LANE_P: lane_sum = sum_acc[0];
      rpa_pkg::LANE_I: lane_sum = sum_acc[1];
      default:         lane_sum = sum_acc[2];
    endcase
  end
  assign lane_mag = lane_sum[SW-1] ? SW'(0) - lane_sum : lane_sum;

  // operand selection for the shared units
  always_comb begin
    mul_cand = rpa_pkg::MCAND_W'(diff_mag);
    mul_plr  = rpa_pkg::FOUR_OVER_PI;
    div_num  = m_acc[DW-1:0];
    div_den  = DW'({amp_mag, {rpa_pkg::DEN_SHIFT{1'b0}}});
    div_neg  = diff[VW] ^ amp[VW];
    case (cmd.sel)
      rpa_pkg::SEL_KU: ;
      rpa_pkg::SEL_KP: begin
        mul_cand = rpa_pkg::MCAND_W'(ku_mag);
        mul_plr  = rpa_pkg::RECIP_5;
      end
      rpa_pkg::SEL_KI: begin
        div_num = DW'({kp_mag, 1'b0});
        div_den = DW'(tu);
        div_neg = gain_p[VW-1];
      end
      rpa_pkg::SEL_KD: begin
        mul_cand = kp33;
        mul_plr  = rpa_pkg::MPLR_W'(tu);
      end
      rpa_pkg::SEL_KD_SCALE: begin
        mul_cand = m_acc[rpa_pkg::MCAND_W-1:0];
        mul_plr  = rpa_pkg::RECIP_100;
      end
      rpa_pkg::SEL_AVG: begin
        div_num = DW'(lane_mag);
        div_den = DW'(avg_n);
        div_neg = lane_sum[SW-1];
      end
      default: ;
    endcase
  end

  always_comb begin
    if (div_den == '0) begin
      if (div_num == '0) q_sat = '0;
      else q_sat = div_neg ? rpa_pkg::VAL_MIN : rpa_pkg::VAL_MAX;
    end else begin
      q_sat = rpa_pkg::sat_val(div_neg, d_quo);
    end
  end

  // quotient by a constant from the reciprocal product
  assign rec_quo = (cmd.sel == rpa_pkg::SEL_KP) ? DW'(m_acc >> rpa_pkg::KP_SHIFT)
                                                 : DW'(m_acc >> rpa_pkg::KD_SHIFT);

  // sample step
  assign half_inc      = (half_count == '1) ? half_count : half_count + CW'(1);
  assign peak_high_new = (in_sample > peak_high) ? in_sample : peak_high;
  assign peak_low_new  = (in_sample < peak_low) ? in_sample : peak_low;
  assign sw_down       = relay_state && (in_sample > set_point);
  assign sw_up         = !relay_state && (in_sample < set_point);

  assign d_trial = {d_rem, d_quo[DW-1]};
  assign d_ge    = (d_trial >= {1'b0, d_den});

  assign status.start_item = !in_action;
  assign status.running    = running;
  assign status.up_switch  = sw_up;
  assign status.mul_busy   = m_busy;
  assign status.div_busy   = d_busy;
  assign status.fin_due    = (cycle_count >= cycle_target);
  assign status.n_zero     = (avg_n == '0);
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    logic signed [SW:0] s;
    if (rst) begin
      set_point    <= '0;
      out_min      <= '0;
      out_max      <= VW'(1) <<< rpa_pkg::FRAC_W;
      cycle_target <= TW'(5);
      relay_state  <= 1'b0;
      running      <= 1'b0;
      cycle_count  <= '0;
      peak_high    <= rpa_pkg::VAL_MIN;
      peak_low     <= rpa_pkg::VAL_MAX;
      half_count   <= '0;
      high_dur     <= '0;
      low_dur      <= '0;
      for (int i = 0; i < 3; i++) sum_acc[i] <= '0;
      gain_p       <= '0;
      gain_i       <= '0;
      gain_d       <= '0;
      m_busy       <= 1'b0;
      d_busy       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rpa_pkg::REG_SET_POINT:    set_point    <= cfg_data;
          rpa_pkg::REG_OUT_MIN:      out_min      <= cfg_data;
          rpa_pkg::REG_OUT_MAX:      out_max      <= cfg_data;
          rpa_pkg::REG_CYCLE_TARGET: cycle_target <= cfg_data[TW-1:0];
          default: ;
        endcase
      end

      if (cmd.load) begin
        if (!in_action) begin
          cycle_count <= '0;
          relay_state <= 1'b1;
          running     <= 1'b1;
          half_count  <= '0;
          high_dur    <= '0;
          low_dur     <= '0;
          peak_high   <= rpa_pkg::VAL_MIN;
          peak_low    <= rpa_pkg::VAL_MAX;
          for (int i = 0; i < 3; i++) sum_acc[i] <= '0;
        end else if (running) begin
          peak_low <= peak_low_new;
          if (sw_down) begin
            relay_state <= 1'b0;
            high_dur    <= half_inc;
            half_count  <= '0;
            peak_high   <= set_point;
          end else if (sw_up) begin
            relay_state <= 1'b1;
            low_dur     <= half_inc;
            half_count  <= '0;
            peak_high   <= peak_high_new;
          end else begin
            half_count <= half_inc;
            peak_high  <= peak_high_new;
          end
        end
      end

      if (cmd.wr) begin
        case (cmd.sel)
          rpa_pkg::SEL_KU: ku     <= q_sat;
          rpa_pkg::SEL_KP: gain_p <= rpa_pkg::sat_val(ku[VW-1], rec_quo);
          rpa_pkg::SEL_KI: gain_i <= q_sat;
          rpa_pkg::SEL_KD_SCALE: begin
            if (kd_big) gain_d <= gain_p[VW-1] ? rpa_pkg::VAL_MIN : rpa_pkg::VAL_MAX;
            else gain_d <= rpa_pkg::sat_val(gain_p[VW-1], rec_quo);
          end
          rpa_pkg::SEL_AVG: begin
            case (cmd.lane)
              rpa_pkg::LANE_P: gain_p <= q_sat;
              rpa_pkg::LANE_I: gain_i <= q_sat;
              default:         gain_d <= q_sat;
            endcase
          end
          default: ;
        endcase
      end

      if (cmd.apply_up) begin
        if (cycle_count >= TW'(2)) begin
          for (int i = 0; i < 3; i++) begin
            s = {sum_acc[i][SW-1], sum_acc[i]}
              + (SW+1)'(i == 0 ? gain_p : (i == 1 ? gain_i : gain_d));
            if (s[SW] != s[SW-1]) sum_acc[i] <= {s[SW], {(SW-1){~s[SW]}}};
            else sum_acc[i] <= s[SW-1:0];
          end
        end
        peak_low <= set_point;
        if (cycle_count != '1) cycle_count <= cycle_count + TW'(1);
      end

      if (cmd.finish) begin
        running     <= 1'b0;
        relay_state <= 1'b0;
        if (avg_n == '0) begin
          gain_p <= '0;
          gain_i <= '0;
          gain_d <= '0;
        end
      end

      if (cmd.mul_go) begin
        // kd product too large for the reciprocal step saturates gain_d
        if (cmd.sel == rpa_pkg::SEL_KD_SCALE)
          kd_big <= (m_acc[PW-1:rpa_pkg::KD_X_W] != '0);
        m_acc  <= '0;
        m_cand <= PW'(mul_cand);
        m_plr  <= mul_plr;
        m_cnt  <= rpa_pkg::MCNT_W'(rpa_pkg::MPLR_W);
        m_busy <= 1'b1;
      end else if (m_busy) begin
        if (m_plr[0]) m_acc <= m_acc + m_cand;
        m_cand <= m_cand << 1;
        m_plr  <= m_plr >> 1;
        m_cnt  <= m_cnt - rpa_pkg::MCNT_W'(1);
        if (m_cnt == rpa_pkg::MCNT_W'(1)) m_busy <= 1'b0;
      end

      if (cmd.div_go) begin
        d_rem  <= '0;
        d_quo  <= div_num;
        d_den  <= div_den;
        d_cnt  <= rpa_pkg::DCNT_W'(DW);
        d_busy <= 1'b1;
      end else if (d_busy) begin
        d_rem  <= d_ge ? DW'(d_trial - {1'b0, d_den}) : d_trial[DW-1:0];
        d_quo  <= {d_quo[DW-2:0], d_ge};
        d_cnt  <= d_cnt - rpa_pkg::DCNT_W'(1);
        if (d_cnt == rpa_pkg::DCNT_W'(1)) d_busy <= 1'b0;
      end

      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // result register, payload needs no reset
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_drive    <= relay_state ? out_max : out_min;
      out_relay    <= relay_state;
      out_finished <= (cycle_count >= cycle_target);
      out_gain_p   <= gain_p;
      out_gain_i   <= gain_i;
      out_gain_d   <= gain_d;
    end
  end

endmodule

[hw/rtl/relay_pid_autotuner.sv]
// channel   dir  payload                                        handshake
// samples   in   action, sample_value                           valid/ready
// results   out  drive_value, relay_high, finished, gain_p/i/d  valid/ready
// cfg       in   cfg_index, cfg_data                            cfg_we, no wait
//
// one item at a time; a sample without a relay switch passes the finish check, then
// output, a start goes straight to output; an upward switch adds four 39-step
// shift-add multiplies (the divides by 5 and 100 are reciprocal multiplies) and two
// 64-step divides; finishing adds three more divides if avg_n is nonzero
// the result sits in an output register, so a stalled result only holds the next one
// rst is synchronous, active high; it restores the register defaults and tuning state
module relay_pid_autotuner (
  input  logic                        clk,
  input  logic                        rst,
  rpa_in_if.sink                      samples,
  rpa_out_if.source                   results,
  input  logic                        cfg_we,
  input  logic [rpa_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rpa_pkg::VAL_W-1:0]   cfg_data
);

  rpa_pkg::cmd_t    cmd;
  rpa_pkg::status_t status;

  rpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rpa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_action    (samples.action),
    .in_sample    (samples.sample_value),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (results.ready),
    .out_valid    (results.valid),
    .out_drive    (results.drive_value),
    .out_relay    (results.relay_high),
    .out_finished (results.finished),
    .out_gain_p   (results.gain_p),
    .out_gain_i   (results.gain_i),
    .out_gain_d   (results.gain_d)
  );

endmodule

[hw/rtl/rpa_checker.sv]
module rpa_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [rpa_pkg::VAL_W-1:0]  out_drive,
  input logic                              out_relay,
  input logic                              out_finished,
  input logic signed [rpa_pkg::VAL_W-1:0]  out_gain_p,
  input logic signed [rpa_pkg::VAL_W-1:0]  out_gain_i,
  input logic signed [rpa_pkg::VAL_W-1:0]  out_gain_d
);

  // one item in flight: no new beat right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  // a reset leaves no result valid
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // result never appears while the input side is still open for the same item
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without a work cycle");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_drive) && $stable(out_relay)
      && $stable(out_finished) && $stable(out_gain_p) && $stable(out_gain_i)
      && $stable(out_gain_d))
    else $error("stalled result changed");

endmodule

bind relay_pid_autotuner rpa_checker u_rpa_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (samples.valid),
  .in_ready     (samples.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_drive    (results.drive_value),
  .out_relay    (results.relay_high),
  .out_finished (results.finished),
  .out_gain_p   (results.gain_p),
  .out_gain_i   (results.gain_i),
  .out_gain_d   (results.gain_d)
);

[test/relay_pid_autotuner_checker.sv]
module relay_pid_autotuner_checker (
  input  logic                      clk,
  input  logic                      rst,
  rpa_in_if                         samples,
  rpa_out_if                        results,
  input  logic                      cfg_we,
  input  logic [rpa_pkg::IDX_W-1:0] cfg_index,
  input  logic [rpa_pkg::VAL_W-1:0] cfg_data,
  output int                        errors,
  output int                        pending,
  output int                        n_checked,
  output int                        n_finished
);
  timeunit 1ns;
  timeprecision 1ps;
  import rpa_pkg::*;

  localparam logic ACT_START = 1'b0;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint SUM_MAX = 64'sd140737488355327;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam bit [63:0] COUNT_MAX = 64'hFFFF_FFFF;

  typedef struct {
    logic [31:0] drive_value;
    logic        relay_high;
    logic        finished;
    logic [31:0] gain_p;
    logic [31:0] gain_i;
    logic [31:0] gain_d;
  } tune_result_t;

  tune_result_t expected_results[$];

  longint    set_point, out_min, out_max;
  bit [7:0]  cycle_target;
  bit        relay_on, tuning;
  bit [7:0]  cycle_cnt;
  longint    peak_hi, peak_lo;
  bit [63:0] half_cnt, high_len, low_len;
  longint    gain_acc[3];
  longint    gain_out[3];

  function automatic bit [63:0] mag(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint div_sat(input bit neg, input bit [63:0] num,
                                     input bit [63:0] den);
    bit [63:0] q;
    if (den == 0) begin
      if (num == 0) return 0;
      return neg ? S32_MIN : S32_MAX;
    end
    q = num / den;
    if (neg) return q > 64'd2147483648 ? S32_MIN : -longint'(q);
    return q > 64'd2147483647 ? S32_MAX : longint'(q);
  endfunction

  task automatic clear_tuning();
    relay_on = 0; tuning = 0; cycle_cnt = 0;
    peak_hi = S32_MIN; peak_lo = S32_MAX;
    half_cnt = 0; high_len = 0; low_len = 0;
    for (int i = 0; i < 3; i++) begin
      gain_acc[i] = 0; gain_out[i] = 0;
    end
  endtask

  task automatic update_gains();
    longint    d, a, ku, kp, s;
    bit [63:0] tu, num, den, m;
    d = out_max - out_min;
    a = peak_hi - peak_lo;
    tu = high_len + low_len;
    num = mag(d) * 64'(FOUR_OVER_PI);
    den = mag(a) << DEN_SHIFT;
    ku = div_sat((d < 0) != (a < 0), num, den);
    kp = ku / 5;
    m = mag(kp) * 64'd33;
    gain_out[0] = kp;
    gain_out[1] = div_sat(kp < 0, mag(kp) * 64'd2, tu);
    if (tu != 0 && m > 64'hFFFF_FFFF_FFFF_FFFF / tu)
      gain_out[2] = kp < 0 ? S32_MIN : S32_MAX;
    else
      gain_out[2] = div_sat(kp < 0, m * tu, 64'd100);
    if (cycle_cnt >= 2) begin
      for (int i = 0; i < 3; i++) begin
        s = gain_acc[i] + gain_out[i];
        gain_acc[i] = s > SUM_MAX ? SUM_MAX : (s < SUM_MIN ? SUM_MIN : s);
      end
    end
  endtask

  task automatic predict_beat(input logic act, input logic signed [31:0] val);
    longint       x;
    bit [63:0]    n;
    tune_result_t r;
    x = val;
    if (act == ACT_START) begin
      cycle_cnt = 0; relay_on = 1; tuning = 1;
      half_cnt = 0; high_len = 0; low_len = 0;
      peak_hi = S32_MIN; peak_lo = S32_MAX;
      for (int i = 0; i < 3; i++) gain_acc[i] = 0;
    end else if (tuning) begin
      half_cnt = half_cnt >= COUNT_MAX ? COUNT_MAX : half_cnt + 1;
      if (x > peak_hi) peak_hi = x;
      if (x < peak_lo) peak_lo = x;
      if (relay_on && x > set_point) begin
        relay_on = 0;
        high_len = half_cnt;
        half_cnt = 0;
        peak_hi = set_point;
      end else if (!relay_on && x < set_point) begin
        relay_on = 1;
        low_len = half_cnt;
        half_cnt = 0;
        update_gains();
        peak_lo = set_point;
        if (cycle_cnt < 255) cycle_cnt++;
      end
      if (cycle_cnt >= cycle_target) begin
        n = cycle_cnt >= 2 ? 64'(cycle_cnt - 2) : 64'd0;
        tuning = 0;
        relay_on = 0;
        for (int i = 0; i < 3; i++)
          gain_out[i] = n == 0 ? 0 : div_sat(gain_acc[i] < 0, mag(gain_acc[i]), n);
      end
    end
    r.drive_value = relay_on ? out_max[31:0] : out_min[31:0];
    r.relay_high  = relay_on;
    r.finished    = cycle_cnt >= cycle_target;
    r.gain_p      = gain_out[0][31:0];
    r.gain_i      = gain_out[1][31:0];
    r.gain_d      = gain_out[2][31:0];
    expected_results.push_back(r);
  endtask

  task automatic compare_beat();
    tune_result_t e;
    if (expected_results.size() == 0) begin
      $error("result beat with no expectation waiting");
      errors++;
      return;
    end
    e = expected_results.pop_front();
    n_checked++;
    if (results.finished) n_finished++;
    if (results.drive_value !== e.drive_value) begin
      $error("drive_value: expected %0h, got %0h", e.drive_value, results.drive_value);
      errors++;
    end
    if (results.relay_high !== e.relay_high) begin
      $error("relay_high: expected %0b, got %0b", e.relay_high, results.relay_high);
      errors++;
    end
    if (results.finished !== e.finished) begin
      $error("finished: expected %0b, got %0b", e.finished, results.finished);
      errors++;
    end
    if (results.gain_p !== e.gain_p) begin
      $error("gain_p: expected %0h, got %0h", e.gain_p, results.gain_p);
      errors++;
    end
    if (results.gain_i !== e.gain_i) begin
      $error("gain_i: expected %0h, got %0h", e.gain_i, results.gain_i);
      errors++;
    end
    if (results.gain_d !== e.gain_d) begin
      $error("gain_d: expected %0h, got %0h", e.gain_d, results.gain_d);
      errors++;
    end
  endtask

  initial begin
    errors = 0; n_checked = 0; n_finished = 0;
    clear_tuning();
  end

  always @(posedge clk) begin
    if (rst) begin
      set_point = 0; out_min = 0; out_max = 65536; cycle_target = 5;
      clear_tuning();
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SET_POINT:    set_point = longint'($signed(cfg_data));
          REG_OUT_MIN:      out_min = longint'($signed(cfg_data));
          REG_OUT_MAX:      out_max = longint'($signed(cfg_data));
          REG_CYCLE_TARGET: cycle_target = cfg_data[7:0];
          default: ;
        endcase
      end
      if (results.valid && results.ready) compare_beat();
      if (samples.valid && samples.ready) predict_beat(samples.action, samples.sample_value);
    end
    pending = expected_results.size();
  end

endmodule

[test/relay_pid_autotuner_tb.sv]
module relay_pid_autotuner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rpa_pkg::*;

  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;
  localparam int   ITEM_GOAL  = 1750;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0] cfg_data = '0;
  int errors, pending, n_checked, n_finished;
  int items_sent = 0;
  bit quiet = 0;
  bit hold_done = 0;
  longint sp_now = 0;

  rpa_in_if  samples();
  rpa_out_if results();

  relay_pid_autotuner u_top (
    .clk(clk), .rst(rst), .samples(samples), .results(results),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  relay_pid_autotuner_checker u_chk (
    .clk(clk), .rst(rst), .samples(samples), .results(results),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .n_checked(n_checked), .n_finished(n_finished)
  );

  always #5 clk = ~clk;

  initial begin
    #50ms;
    $display("[relay_pid_autotuner] ERROR");
    $finish;
  end

  // result side: random stall bursts, one long hold to back the block up
  initial begin
    results.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && n_checked >= 120) begin
        hold_done = 1;
        results.ready = 0;
        repeat (600) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        results.ready = 0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        results.ready = 1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  // called at a falling edge; returns at a falling edge after the beat, at times after a random idle gap
  task automatic send(input logic act, input logic [31:0] val);
    bit took;
    samples.valid = 1;
    samples.action = act;
    samples.sample_value = val;
    do begin
      #1 took = samples.ready;
      @(posedge clk);
      @(negedge clk);
    end while (!took);
    items_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      samples.valid = 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we = 1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic configure(input logic [31:0] sp, input logic [31:0] lo,
                           input logic [31:0] hi, input logic [7:0] tgt);
    samples.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    write_reg(REG_SET_POINT, sp);
    write_reg(REG_OUT_MIN, lo);
    write_reg(REG_OUT_MAX, hi);
    write_reg(REG_CYCLE_TARGET, {24'd0, tgt});
    sp_now = longint'($signed(sp));
  endtask

  function automatic logic [31:0] near_sp(input bit above, input longint amp);
    longint v;
    v = above ? sp_now + 1 + longint'($urandom_range(0, 32'(amp)))
              : sp_now - 1 - longint'($urandom_range(0, 32'(amp)));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // a start, then relay cycles around the set point with the odd noise beat
  task automatic tune_run(input int cycles);
    longint amp;
    amp = longint'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 200000));
    send(ACT_START, $urandom);
    for (int c = 0; c < cycles; c++) begin
      repeat ($urandom_range(1, 6)) send(ACT_SAMPLE, near_sp(1'b1, amp));
      repeat ($urandom_range(1, 6)) send(ACT_SAMPLE, near_sp(1'b0, amp));
      if ($urandom_range(0, 9) == 0) send(ACT_SAMPLE, $urandom);
    end
  endtask

  initial begin
    samples.valid = 0;
    samples.action = ACT_SAMPLE;
    samples.sample_value = '0;
    repeat (11) @(negedge clk);
    rst = 0;

    // samples before any start, then field extremes inside a run
    send(ACT_SAMPLE, 32'h7FFF_FFFF);
    send(ACT_SAMPLE, 32'h8000_0000);
    send(ACT_START, 32'h0);
    send(ACT_SAMPLE, 32'h7FFF_FFFF);
    send(ACT_SAMPLE, 32'h8000_0000);
    send(ACT_SAMPLE, 32'hFFFF_FFFF);
    send(ACT_SAMPLE, 32'h0000_0001);
    send(ACT_SAMPLE, 32'hFFFF_FFFF);
    tune_run(6);

    // target met at once, and finishing with nothing summed
    configure(32'h0, 32'h0, 32'h0001_0000, 8'd0);
    send(ACT_SAMPLE, 32'h5);
    send(ACT_START, 32'h0);
    send(ACT_SAMPLE, 32'h5);
    configure(32'h0, 32'hFFFF_0000, 32'h0002_0000, 8'd2);
    tune_run(3);
    // zero drive swing and reversed swing
    configure(32'h0001_0000, 32'h0003_0000, 32'h0003_0000, 8'd3);
    tune_run(4);
    configure(32'hFFF0_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'd4);
    tune_run(5);
    // set point at the extremes
    configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'd3);
    tune_run(2);
    configure(32'h8000_0000, 32'h0, 32'h1234_5678, 8'd3);
    tune_run(2);

    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 5))
        0: configure($urandom, $urandom, $urandom, 8'($urandom_range(3, 8)));
        1: configure(32'($signed($urandom_range(0, 400000)) - 200000), 32'hFFFF_0000,
                     32'h0001_0000, $urandom_range(0, 9) == 0 ? 8'd255 : 8'd5);
        default: configure(32'($signed($urandom_range(0, 40000)) - 20000),
                           $urandom_range(0, 65536), 32'h0004_0000 + $urandom_range(0, 65536),
                           8'($urandom_range(1, 7)));
      endcase
      repeat ($urandom_range(1, 3)) begin
        if (items_sent > ITEM_GOAL - 200) quiet = 1;
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 6)) send(1'($urandom), $urandom);
        else tune_run($urandom_range(2, 10));
      end
    end
    samples.valid = 0;
    quiet = 1;

    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    $display("checked %0d results for %0d sample/start beats, %0d reported finished",
             n_checked, items_sent, n_finished);
    if (errors == 0 && pending == 0) begin
      $display("[relay_pid_autotuner] OK");
    end else begin
      $display("[relay_pid_autotuner] ERROR");
    end
    $finish;
  end

endmodule
